### src/operation_id_tracking_table_macros.svh
// Assertion macros for the operation ID tracking table.
// Used by the top level; needs nothing else.
`ifndef OPERATION_ID_TRACKING_TABLE_MACROS_SVH
`define OPERATION_ID_TRACKING_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OITT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("operation ID tracking table: check failed");

// Next-cycle implication, disabled during reset.
`define OITT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("operation ID tracking table: check failed");

`endif

### src/oitt_pkg.sv
// Shared types for the operation ID tracking table.
// No dependencies; imported by the slot cell, the top level and the testbench.
package oitt_pkg;

   typedef enum logic [1:0] {
      OP_RESERVE  = 2'd0,
      OP_ACCEPT   = 2'd1,
      OP_ROLLBACK = 2'd2,
      OP_COMPLETE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      SLOT_FREE = 2'd0,
      SLOT_PROV = 2'd1,
      SLOT_ACC  = 2'd2
   } slot_state_type;

   // Control part of a token moving down the slot chain.
   typedef struct packed {
      logic   valid;
      logic   act;    // 1 action token, 0 probe token
      op_type op;
      logic   en;     // action allowed to claim a slot
      logic   qok;    // external queue outcome
      logic   hit;    // probe: ID live; action: slot found
   } tok_ctl_type;

endpackage

### src/oitt_cell.sv
// One slot record of the operation ID tracking table and its chain stage.
// Depends on oitt_pkg.
module oitt_cell import oitt_pkg::*; #(
   parameter int ID_BITS  = 16,
   parameter int CNT_BITS = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  tok_ctl_type         in_ctl,
   input  logic [ID_BITS-1:0]  in_id,
   input  logic [CNT_BITS-1:0] in_cnt,
   output tok_ctl_type         out_ctl,
   output logic [ID_BITS-1:0]  out_id,
   output logic [CNT_BITS-1:0] out_cnt
);

   slot_state_type      state_ff, state_in;
   logic [ID_BITS-1:0]  id_ff, id_in;
   tok_ctl_type         out_ctl_ff, out_ctl_in;
   logic [ID_BITS-1:0]  out_id_ff;
   logic [CNT_BITS-1:0] out_cnt_ff, out_cnt_in;
   logic                match;
   logic                take;

   assign match = (state_ff != SLOT_FREE) && (id_ff == in_id);

   always_comb begin
      state_in   = state_ff;
      id_in      = id_ff;
      out_ctl_in = in_ctl;
      out_cnt_in = in_cnt;
      take       = 1'b0;
      if (in_ctl.valid && !in_ctl.act) begin
         out_ctl_in.hit = in_ctl.hit | match;
      end else if (in_ctl.valid && in_ctl.act) begin
         case (in_ctl.op)
            OP_RESERVE: begin
               take = in_ctl.en && !in_ctl.hit && (state_ff == SLOT_FREE);
               if (take) begin
                  state_in = SLOT_PROV;
                  id_in    = in_id;
               end
            end
            OP_ACCEPT: begin
               take = in_ctl.en && !in_ctl.hit && match && (state_ff == SLOT_PROV);
               if (take) state_in = SLOT_ACC;
            end
            OP_ROLLBACK: begin
               take = in_ctl.en && !in_ctl.hit && match && (state_ff == SLOT_PROV);
               if (take) begin
                  state_in = SLOT_FREE;
                  id_in    = '0;
               end
            end
            OP_COMPLETE: begin
               take = in_ctl.en && !in_ctl.hit && match && (state_ff == SLOT_ACC);
               if (take && in_ctl.qok) begin
                  state_in = SLOT_FREE;
                  id_in    = '0;
               end
            end
            default: take = 1'b0;
         endcase
         out_ctl_in.hit = in_ctl.hit | take;
         out_cnt_in     = in_cnt + CNT_BITS'(state_in != SLOT_FREE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= SLOT_FREE;
         out_ctl_ff <= '0;
      end else begin
         state_ff   <= state_in;
         out_ctl_ff <= out_ctl_in;
      end
      id_ff      <= id_in;
      out_id_ff  <= in_id;
      out_cnt_ff <= out_cnt_in;
   end

   assign out_ctl = out_ctl_ff;
   assign out_id  = out_id_ff;
   assign out_cnt = out_cnt_ff;

endmodule

### src/operation_id_tracking_table.sv
// Operation ID tracking table: top level, request sequencer and slot chain.
// Depends on oitt_pkg, oitt_cell and operation_id_tracking_table_macros.svh.
//
// Usage:
//  - Raise start with the req_ fields; the request is taken at the edge where
//    start is high and busy is low. busy stays high until the response is out.
//  - One response per request: rsp_valid is high for exactly one cycle with
//    the rsp_ fields. The receiver cannot stall; capture it in that cycle.
//  - The slots form a chain of SLOTS cells; a token advances one cell a cycle.
//  - Reserve streams up to SLOTS+2 candidate IDs through the chain, one per
//    cycle, stops at the first one no cell reports live, then sends an action
//    token that claims the lowest free slot. The response comes once the probe
//    stream and then the action token have each crossed the chain; every live
//    candidate ahead of the winner lengthens the probe walk.
//  - Accept, rollback and complete send only the action token through the chain.
//  - One request at a time; start may be high while rsp_valid is, and the next
//    request is then taken at the edge that ends the response cycle.
//  - Reset frees all slots at once and clears the ID cursor (read as 1).
`include "operation_id_tracking_table_macros.svh"

module operation_id_tracking_table import oitt_pkg::*; #(
   parameter int SLOTS   = 16,
   parameter int ID_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_op_id,
   input  logic        req_queue_ok,
   input  logic [7:0]  req_error_code,
   input  logic [15:0] req_sip_status,
   output logic        rsp_valid,
   output logic        rsp_success,
   output logic [15:0] rsp_result_id,
   output logic        rsp_terminal_emit,
   output logic [7:0]  rsp_terminal_error,
   output logic [15:0] rsp_terminal_status,
   output logic [4:0]  rsp_active_count
);

   localparam int CNT_BITS = $clog2(SLOTS + 1);
   localparam int PROBES   = SLOTS + 2;
   localparam int PW       = $clog2(PROBES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_ACT_SEND,
      ST_ACT_WAIT
   } fsm_type;

   // Next ID after v, skipping zero.
   function automatic logic [ID_BITS-1:0] step_id(input logic [ID_BITS-1:0] v);
      logic [ID_BITS-1:0] n;
      n = v + ID_BITS'(1);
      return (n == '0) ? ID_BITS'(1) : n;
   endfunction

   // Chain wiring: index 0 is the injection point, SLOTS the far end.
   tok_ctl_type         chain_ctl [SLOTS+1];
   logic [ID_BITS-1:0]  chain_id  [SLOTS+1];
   logic [CNT_BITS-1:0] chain_cnt [SLOTS+1];

   fsm_type             state_ff, state_in;
   op_type              op_ff, op_in;
   logic [15:0]         opid_ff, opid_in;
   logic                qok_ff, qok_in;
   logic [7:0]          err_ff, err_in;
   logic [15:0]         sip_ff, sip_in;
   logic [ID_BITS-1:0]  cursor_ff, cursor_in;
   logic [ID_BITS-1:0]  cand_ff, cand_in;
   logic [PW-1:0]       inj_cnt_ff, inj_cnt_in;
   logic [PW-1:0]       rx_cnt_ff, rx_cnt_in;
   logic [ID_BITS-1:0]  win_ff, win_in;
   logic                win_ok_ff, win_ok_in;
   tok_ctl_type         inj_ctl_ff, inj_ctl_in;
   logic [ID_BITS-1:0]  inj_id_ff, inj_id_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_success_ff, rsp_success_in;
   logic [15:0]         rsp_result_id_ff, rsp_result_id_in;
   logic                rsp_emit_ff, rsp_emit_in;
   logic [7:0]          rsp_error_ff, rsp_error_in;
   logic [15:0]         rsp_status_ff, rsp_status_in;
   logic [CNT_BITS-1:0] rsp_count_ff, rsp_count_in;

   logic [ID_BITS-1:0]  opid_ext;
   logic                opid_ok;
   tok_ctl_type         tail_ctl;
   logic                probe_out;
   logic                act_out;

   // An op_id names a record only if nonzero and it fits in ID_BITS.
   assign opid_ext  = ID_BITS'(opid_ff);
   assign opid_ok   = (opid_ff != 16'd0) && (16'(opid_ext) == opid_ff);
   assign tail_ctl  = chain_ctl[SLOTS];
   assign probe_out = tail_ctl.valid && !tail_ctl.act;
   assign act_out   = tail_ctl.valid && tail_ctl.act;

   assign chain_ctl[0] = inj_ctl_ff;
   assign chain_id[0]  = inj_id_ff;
   assign chain_cnt[0] = '0;

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      oitt_cell #(
         .ID_BITS  (ID_BITS),
         .CNT_BITS (CNT_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .in_ctl  (chain_ctl[g]),
         .in_id   (chain_id[g]),
         .in_cnt  (chain_cnt[g]),
         .out_ctl (chain_ctl[g+1]),
         .out_id  (chain_id[g+1]),
         .out_cnt (chain_cnt[g+1])
      );
   end

   always_comb begin
      state_in         = state_ff;
      op_in            = op_ff;
      opid_in          = opid_ff;
      qok_in           = qok_ff;
      err_in           = err_ff;
      sip_in           = sip_ff;
      cursor_in        = cursor_ff;
      cand_in          = cand_ff;
      inj_cnt_in       = inj_cnt_ff;
      rx_cnt_in        = rx_cnt_ff;
      win_in           = win_ff;
      win_ok_in        = win_ok_ff;
      inj_ctl_in       = '0;
      inj_id_in        = inj_id_ff;
      rsp_valid_in     = 1'b0;
      rsp_success_in   = rsp_success_ff;
      rsp_result_id_in = rsp_result_id_ff;
      rsp_emit_in      = rsp_emit_ff;
      rsp_error_in     = rsp_error_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_count_in     = rsp_count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in      = op_type'(req_operation);
               opid_in    = req_op_id;
               qok_in     = req_queue_ok;
               err_in     = req_error_code;
               sip_in     = req_sip_status;
               cand_in    = (cursor_ff == '0) ? ID_BITS'(1) : cursor_ff;
               inj_cnt_in = '0;
               rx_cnt_in  = '0;
               win_ok_in  = 1'b0;
               state_in   = (op_type'(req_operation) == OP_RESERVE) ? ST_PROBE : ST_ACT_SEND;
            end
         end
         ST_PROBE: begin
            // Drop in-flight probes once decided; they change no slot.
            if (probe_out && (!tail_ctl.hit || rx_cnt_ff == PW'(PROBES - 1))) begin
               win_in    = chain_id[SLOTS];
               win_ok_in = !tail_ctl.hit && qok_ff;
               state_in  = ST_ACT_SEND;
            end else begin
               if (probe_out) rx_cnt_in = rx_cnt_ff + PW'(1);
               // Advance the candidate stream, one ID per cycle.
               if (inj_cnt_ff < PW'(PROBES)) begin
                  inj_ctl_in.valid = 1'b1;
                  inj_ctl_in.op    = OP_RESERVE;
                  inj_id_in        = cand_ff;
                  cand_in          = step_id(cand_ff);
                  inj_cnt_in       = inj_cnt_ff + PW'(1);
               end
            end
         end
         ST_ACT_SEND: begin
            inj_ctl_in.valid = 1'b1;
            inj_ctl_in.act   = 1'b1;
            inj_ctl_in.op    = op_ff;
            inj_ctl_in.qok   = qok_ff;
            inj_ctl_in.en    = (op_ff == OP_RESERVE) ? win_ok_ff : opid_ok;
            inj_id_in        = (op_ff == OP_RESERVE) ? win_ff : opid_ext;
            state_in         = ST_ACT_WAIT;
         end
         ST_ACT_WAIT: begin
            if (act_out) begin
               rsp_valid_in     = 1'b1;
               rsp_count_in     = chain_cnt[SLOTS];
               rsp_result_id_in = '0;
               rsp_emit_in      = 1'b0;
               rsp_error_in     = '0;
               rsp_status_in    = '0;
               case (op_ff)
                  OP_RESERVE: begin
                     rsp_success_in = tail_ctl.hit;
                     if (tail_ctl.hit) begin
                        rsp_result_id_in = 16'(win_ff);
                        cursor_in        = step_id(win_ff);
                     end
                  end
                  OP_ACCEPT: rsp_success_in = tail_ctl.hit;
                  OP_ROLLBACK: begin
                     rsp_success_in = tail_ctl.hit && qok_ff;
                     // Hand the ID back if nothing moved the cursor past it.
                     if (tail_ctl.hit && cursor_ff == step_id(opid_ext)) cursor_in = opid_ext;
                  end
                  OP_COMPLETE: begin
                     rsp_success_in = tail_ctl.hit && qok_ff;
                     if (tail_ctl.hit && qok_ff) begin
                        rsp_emit_in   = 1'b1;
                        rsp_error_in  = err_ff;
                        rsp_status_in = sip_ff;
                     end
                  end
                  default: rsp_success_in = 1'b0;
               endcase
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         inj_ctl_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         inj_ctl_ff   <= inj_ctl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff            <= op_in;
      opid_ff          <= opid_in;
      qok_ff           <= qok_in;
      err_ff           <= err_in;
      sip_ff           <= sip_in;
      cand_ff          <= cand_in;
      inj_cnt_ff       <= inj_cnt_in;
      rx_cnt_ff        <= rx_cnt_in;
      win_ff           <= win_in;
      win_ok_ff        <= win_ok_in;
      inj_id_ff        <= inj_id_in;
      rsp_success_ff   <= rsp_success_in;
      rsp_result_id_ff <= rsp_result_id_in;
      rsp_emit_ff      <= rsp_emit_in;
      rsp_error_ff     <= rsp_error_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_count_ff     <= rsp_count_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_success         = rsp_success_ff;
   assign rsp_result_id       = rsp_result_id_ff;
   assign rsp_terminal_emit   = rsp_emit_ff;
   assign rsp_terminal_error  = rsp_error_ff;
   assign rsp_terminal_status = rsp_status_ff;
   assign rsp_active_count    = 5'(rsp_count_ff);

   `OITT_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `OITT_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `OITT_ASSERT_NOW(a_emit_success, clock, reset, rsp_valid && rsp_terminal_emit, rsp_success)
   `OITT_ASSERT_NOW(a_fail_no_id, clock, reset, rsp_valid && !rsp_success, rsp_result_id == 16'd0)
   `OITT_ASSERT_NOW(a_count_bound, clock, reset, rsp_valid, rsp_count_ff <= CNT_BITS'(SLOTS))

endmodule

### tb/sv/operation_id_tracking_table_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the operation ID tracking table.
// Holds a scoreboard class that mirrors the slot table, a request driver and a response monitor.
// Depends on oitt_pkg and the operation_id_tracking_table top level.

module operation_id_tracking_table_tb import oitt_pkg::*; ();

   localparam int NUM_SLOTS    = 16;
   localparam int ID_WIDTH     = 16;
   localparam int CLK_HALF     = 10;
   localparam int RANDOM_ITEMS = 1950;
   localparam int DRAIN_CYCLES = 2 * NUM_SLOTS + 12;
   localparam int CYCLE_LIMIT  = 1000000;

   // One response as the table should produce it.
   typedef struct {
      logic        success;
      logic [15:0] result_id;
      logic        terminal_emit;
      logic [7:0]  terminal_error;
      logic [15:0] terminal_status;
      logic [4:0]  active_count;
   } id_table_outcome_type;

   // Mirror of the slot table: predicts each response from the requests taken
   // and checks responses in order against the predictions.
   class id_table_scoreboard #(int SLOTS = 16);
      logic [15:0]          slot_id [SLOTS];
      slot_state_type       slot_st [SLOTS];
      logic [15:0]          cursor;
      id_table_outcome_type outcome_q [$];
      int                   error_count;
      int                   requests_taken;
      int                   reserves_tried;
      int                   reserves_granted;
      int                   terminals_seen;
      int                   peak_active;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            slot_id[i] = '0;
            slot_st[i] = SLOT_FREE;
         end
         cursor = '0;
         error_count = 0;
         requests_taken = 0;
         reserves_tried = 0;
         reserves_granted = 0;
         terminals_seen = 0;
         peak_active = 0;
      endfunction

      // Next candidate after an ID; zero is never handed out.
      function logic [15:0] next_id(logic [15:0] id);
         logic [15:0] n;
         n = id + 16'd1;
         return (n == 16'd0) ? 16'd1 : n;
      endfunction

      function bit id_in_use(logic [15:0] id);
         if (id == 16'd0) return 1'b0;
         for (int i = 0; i < SLOTS; i++)
            if (slot_st[i] != SLOT_FREE && slot_id[i] == id) return 1'b1;
         return 1'b0;
      endfunction

      function int find_record(logic [15:0] id, slot_state_type st);
         if (id == 16'd0) return -1;
         for (int i = 0; i < SLOTS; i++)
            if (slot_st[i] == st && slot_id[i] == id) return i;
         return -1;
      endfunction

      function int records_in_use();
         int n;
         n = 0;
         for (int i = 0; i < SLOTS; i++)
            if (slot_st[i] != SLOT_FREE) n++;
         return n;
      endfunction

      // Random ID held in the given state, or zero when there is none.
      function logic [15:0] pick_id(slot_state_type st);
         logic [15:0] ids [$];
         for (int i = 0; i < SLOTS; i++)
            if (slot_st[i] == st) ids.push_back(slot_id[i]);
         if (ids.size() == 0) return 16'd0;
         return ids[$urandom_range(0, ids.size() - 1)];
      endfunction

      function int pending();
         return outcome_q.size();
      endfunction

      function void note_request(op_type op, logic [15:0] id, bit qok,
                                 logic [7:0] err, logic [15:0] sip);
         id_table_outcome_type o;
         int                   free_slot;
         int                   s;
         logic [15:0]          cand;
         o = '{1'b0, 16'd0, 1'b0, 8'd0, 16'd0, 5'd0};
         requests_taken++;
         case (op)
            OP_RESERVE: begin
               reserves_tried++;
               free_slot = -1;
               for (int i = 0; i < SLOTS; i++)
                  if (free_slot < 0 && slot_st[i] == SLOT_FREE) free_slot = i;
               if (free_slot >= 0) begin
                  // Probe at most SLOTS+1 steps past live IDs.
                  cand = (cursor == 16'd0) ? 16'd1 : cursor;
                  for (int i = 0; i <= SLOTS; i++) begin
                     if (!id_in_use(cand)) break;
                     cand = next_id(cand);
                  end
                  if (!id_in_use(cand) && qok) begin
                     slot_id[free_slot] = cand;
                     slot_st[free_slot] = SLOT_PROV;
                     cursor = next_id(cand);
                     o.success = 1'b1;
                     o.result_id = cand;
                     reserves_granted++;
                  end
               end
            end
            OP_ACCEPT: begin
               s = find_record(id, SLOT_PROV);
               if (s >= 0) begin
                  slot_st[s] = SLOT_ACC;
                  o.success = 1'b1;
               end
            end
            OP_ROLLBACK: begin
               s = find_record(id, SLOT_PROV);
               if (s >= 0) begin
                  // Hand the ID back only if nothing moved the cursor since.
                  if (cursor == next_id(slot_id[s])) cursor = slot_id[s];
                  slot_id[s] = '0;
                  slot_st[s] = SLOT_FREE;
                  o.success = qok;
               end
            end
            default: begin
               s = find_record(id, SLOT_ACC);
               if (s >= 0 && qok) begin
                  slot_id[s] = '0;
                  slot_st[s] = SLOT_FREE;
                  o.success = 1'b1;
                  o.terminal_emit = 1'b1;
                  o.terminal_error = err;
                  o.terminal_status = sip;
                  terminals_seen++;
               end
            end
         endcase
         o.active_count = 5'(records_in_use());
         if (records_in_use() > peak_active) peak_active = records_in_use();
         outcome_q.push_back(o);
      endfunction

      task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
         error_count++;
         $display("MISMATCH %s: got 0x%0h, want 0x%0h (%0d responses pending)",
                  what, got, want, outcome_q.size());
      endtask

      task check_response(logic succ, logic [15:0] rid, logic emit,
                          logic [7:0] terr, logic [15:0] tsta, logic [4:0] cnt);
         id_table_outcome_type w;
         if (outcome_q.size() == 0) begin
            report_mismatch("unexpected response, result_id", rid, 16'd0);
            return;
         end
         w = outcome_q.pop_front();
         if (succ !== w.success)         report_mismatch("success", 16'(succ), 16'(w.success));
         if (rid !== w.result_id)        report_mismatch("result_id", rid, w.result_id);
         if (emit !== w.terminal_emit)
            report_mismatch("terminal_emit", 16'(emit), 16'(w.terminal_emit));
         if (terr !== w.terminal_error)
            report_mismatch("terminal_error", 16'(terr), 16'(w.terminal_error));
         if (tsta !== w.terminal_status) report_mismatch("terminal_status", tsta, w.terminal_status);
         if (cnt !== w.active_count)
            report_mismatch("active_count", 16'(cnt), 16'(w.active_count));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_operation;
   logic [15:0] req_op_id;
   logic        req_queue_ok;
   logic [7:0]  req_error_code;
   logic [15:0] req_sip_status;
   logic        rsp_valid;
   logic        rsp_success;
   logic [15:0] rsp_result_id;
   logic        rsp_terminal_emit;
   logic [7:0]  rsp_terminal_error;
   logic [15:0] rsp_terminal_status;
   logic [4:0]  rsp_active_count;

   id_table_scoreboard #(NUM_SLOTS) sb;
   int  cycle_count;
   bit  fill_mode;

   operation_id_tracking_table #(
      .SLOTS   (NUM_SLOTS),
      .ID_BITS (ID_WIDTH)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_op_id           (req_op_id),
      .req_queue_ok        (req_queue_ok),
      .req_error_code      (req_error_code),
      .req_sip_status      (req_sip_status),
      .rsp_valid           (rsp_valid),
      .rsp_success         (rsp_success),
      .rsp_result_id       (rsp_result_id),
      .rsp_terminal_emit   (rsp_terminal_emit),
      .rsp_terminal_error  (rsp_terminal_error),
      .rsp_terminal_status (rsp_terminal_status),
      .rsp_active_count    (rsp_active_count)
   );

   // Free-running clock, 20 ns period.
   initial clock = 1'b0;
   always #(CLK_HALF) clock = ~clock;

   // Watchdog: stop a hung run at a generous cycle limit.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending", cycle_count, sb.pending());
         $display("operation_id_tracking_table_tb: errors");
         $finish;
      end
   end

   // Response monitor: the receiver never stalls, so capture every strobe.
   // Values read here are the ones present before this edge's updates.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1)
         sb.check_response(rsp_success, rsp_result_id, rsp_terminal_emit,
                           rsp_terminal_error, rsp_terminal_status, rsp_active_count);
   end

   // Present one request and hold it until the table takes it.
   // Leave start high on return; the caller drops it when a gap follows.
   task automatic send_request(op_type op, logic [15:0] id, bit qok,
                               logic [7:0] err, logic [15:0] sip);
      start          <= 1'b1;
      req_operation  <= op;
      req_op_id      <= id;
      req_queue_ok   <= qok;
      req_error_code <= err;
      req_sip_status <= sip;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(op, id, qok, err, sip);
   endtask

   // Drop start and idle for the given number of cycles.
   task automatic idle_cycles(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Draw one random request. Most are well formed: reserves or operations on live records;
   // the rest are noise: unknown IDs, zero IDs and IDs in the wrong state.
   task automatic draw_request(output op_type op, output logic [15:0] id, output bit qok);
      int          active;
      int          roll;
      logic [15:0] prov_id;
      logic [15:0] acc_id;
      active = sb.records_in_use();
      if (active >= NUM_SLOTS) fill_mode = 1'b0;
      else if (active == 0) fill_mode = 1'b1;
      else if ($urandom_range(0, 49) == 0) fill_mode = ~fill_mode;
      qok = ($urandom_range(0, 4) != 0);
      id  = 16'($urandom_range(0, 65535));
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
         op = op_type'($urandom_range(0, 3));
         qok = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 3))
            0: id = 16'd0;
            1: id = sb.pick_id(SLOT_PROV);
            2: id = sb.pick_id(SLOT_ACC);
            default: id = 16'($urandom_range(0, 65535));
         endcase
         return;
      end
      op = OP_RESERVE;
      if ($urandom_range(0, 99) < (fill_mode ? 70 : 20)) return;
      prov_id = sb.pick_id(SLOT_PROV);
      acc_id  = sb.pick_id(SLOT_ACC);
      if (prov_id != 16'd0 && (acc_id == 16'd0 || $urandom_range(0, 1) == 0)) begin
         id = prov_id;
         if ($urandom_range(0, 9) < 6) begin
            op = OP_ACCEPT;
         end else begin
            op = OP_ROLLBACK;
            qok = 1'($urandom_range(0, 1));
         end
      end else if (acc_id != 16'd0) begin
         id = acc_id;
         op = OP_COMPLETE;
      end
   endtask

   initial begin
      op_type      op;
      logic [15:0] id;
      bit          qok;
      int          sent;
      int          burst;

      sb = new();
      fill_mode = 1'b1;
      // Drive every input to a known value before the first edge.
      reset          = 1'b1;
      start          = 1'b0;
      req_operation  = OP_RESERVE;
      req_op_id      = '0;
      req_queue_ok   = 1'b0;
      req_error_code = '0;
      req_sip_status = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part, starting from the reset table (cursor reads as 1).
      send_request(OP_RESERVE,  16'd0,      1'b0, 8'h00, 16'h0000); // queue refuses
      send_request(OP_RESERVE,  16'hFFFF,   1'b1, 8'hFF, 16'hFFFF); // grants ID 1
      send_request(OP_ACCEPT,   16'd0,      1'b1, 8'h00, 16'h0000); // zero ID never matches
      send_request(OP_ACCEPT,   16'hFFFF,   1'b1, 8'h00, 16'h0000); // unknown ID
      idle_cycles(3);
      send_request(OP_ACCEPT,   16'd1,      1'b1, 8'h00, 16'h0000);
      send_request(OP_ACCEPT,   16'd1,      1'b1, 8'h00, 16'h0000); // already accepted
      send_request(OP_ROLLBACK, 16'd1,      1'b1, 8'h00, 16'h0000); // not provisional
      send_request(OP_COMPLETE, 16'd1,      1'b0, 8'h5A, 16'h1234); // commit fails, record stays
      send_request(OP_COMPLETE, 16'd1,      1'b1, 8'hFF, 16'hFFFF); // terminal event
      send_request(OP_COMPLETE, 16'd1,      1'b1, 8'hFF, 16'hFFFF); // record gone
      idle_cycles(1);
      send_request(OP_RESERVE,  16'd0,      1'b1, 8'h00, 16'h0000); // grants ID 2
      send_request(OP_ROLLBACK, 16'd2,      1'b0, 8'h00, 16'h0000); // cancel fails, cursor back
      send_request(OP_RESERVE,  16'd0,      1'b1, 8'h00, 16'h0000); // ID 2 again
      send_request(OP_RESERVE,  16'd0,      1'b1, 8'h00, 16'h0000); // ID 3
      send_request(OP_ROLLBACK, 16'd2,      1'b1, 8'h00, 16'h0000); // cursor moved on, keep it
      send_request(OP_RESERVE,  16'd0,      1'b1, 8'h00, 16'h0000); // ID 4
      send_request(OP_ROLLBACK, 16'd0,      1'b1, 8'h00, 16'h0000);
      send_request(OP_COMPLETE, 16'd0,      1'b1, 8'h00, 16'h0000);
      send_request(OP_COMPLETE, 16'd3,      1'b1, 8'h00, 16'h0000); // still provisional
      send_request(OP_ACCEPT,   16'd3,      1'b1, 8'h00, 16'h0000);
      send_request(OP_COMPLETE, 16'd3,      1'b1, 8'h00, 16'h0000); // event with zero fields
      idle_cycles(7);

      // Random part: bursts of back-to-back requests, separated by gaps that
      // land on every phase of a request in flight.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            draw_request(op, id, qok);
            send_request(op, id, qok, 8'($urandom_range(0, 255)),
                         16'($urandom_range(0, 65535)));
            sent++;
         end
         if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 45));
      end
      start <= 1'b0;

      // Drain: wait for the last response, then a little longer for strays.
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d requests: %0d of %0d reserves granted, %0d terminal events,",
               sb.requests_taken, sb.reserves_granted, sb.reserves_tried, sb.terminals_seen);
      $display("peak occupancy %0d of %0d slots, %0d mismatches",
               sb.peak_active, NUM_SLOTS, sb.error_count);
      if (sb.error_count == 0) begin
         $display("operation_id_tracking_table_tb: clean");
      end else begin
         $display("operation_id_tracking_table_tb: errors");
      end
      $finish;
   end

endmodule
